### hdl/mexp_pkg.sv
// Package for the 64-bit modular exponentiation block.
// Holds payload structs, the sequencer state type and the multiplier request type.
// No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // Input item: one transfer on the input channel
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
  } mexp_in_t;

  // Result item: one transfer on the output channel
  typedef struct packed {
    logic [DATA_W-1:0] power_result;
    logic              zero_modulus_error;
  } mexp_out_t;

  // Operands for one modular product a * b mod m (a < m, m > 0)
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] m;
  } mexp_mul_req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_FINISH
  } mexp_state_e;

endpackage

### hdl/mexp_mulmod.sv
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB first.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_mulmod import mexp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mexp_mul_req_t       req_i,
  output logic                done_o,
  output logic [DATA_W-1:0]   result_o
);

  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] a_q, b_q, m_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  logic [DATA_W:0]   dbl;
  logic [DATA_W-1:0] dbl_red;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sum_red;

  // One Horner step: acc = 2*acc mod m, then add a mod m when the bit is set
  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? DATA_W'(dbl - {1'b0, m_q}) : dbl[DATA_W-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, a_q};
    sum_red = (sum >= {1'b0, m_q}) ? DATA_W'(sum - {1'b0, m_q}) : sum[DATA_W-1:0];
    acc_d   = b_q[DATA_W-1] ? sum_red : dbl_red;
  end

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DATA_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      m_q   <= req_i.m;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[DATA_W-2:0], 1'b0};
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

### hdl/modular_exponentiation_64_top.sv
// Top level of the 64-bit modular exponentiation block.
// Sequencer around one shared bit-serial modular multiplier (mexp_mulmod).
// Depends on mexp_pkg and mexp_mulmod.
`timescale 1ns / 1ps

// Computes base^exponent mod modulus for 64-bit unsigned operands, one item at a time.
// All work runs through a single bit-serial modular multiplier that handles one multiplier
// bit per cycle. An item first reduces the base (one product pass), then for each exponent
// bit up to the highest set one does a square, plus a multiply when the bit is set. A zero
// exponent finishes after the reduction alone; a zero modulus skips the multiplier and gives
// result 0 with the error flag set. When the output register still holds an older result,
// the sequencer waits in its final state until that result is transferred. in_ready_o is
// high only while no item is in progress; a finished result sits in an output register
// until transferred, and the next item may be accepted meanwhile.
module modular_exponentiation_64_top import mexp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mexp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mexp_out_t out_data_o
);

  mexp_state_e state_q, state_d;

  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] base_q, base_d;
  logic [DATA_W-1:0] exp_q, exp_d;
  logic [DATA_W-1:0] mod_q, mod_d;
  logic              err_q, err_d;

  logic              out_valid_q;
  mexp_out_t         out_data_q;
  logic              out_load;

  logic              mul_start;
  mexp_mul_req_t     mul_req;
  logic              mul_done;
  logic [DATA_W-1:0] mul_res;

  // Scratch values for picking the next product after a square or the reduction
  logic [DATA_W-1:0] nxt_exp;
  logic [DATA_W-1:0] nxt_base;
  logic              decide;
  logic [DATA_W-1:0] acc_init;

  mexp_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .req_i    (mul_req),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign acc_init   = (in_data_i.modulus == DATA_W'(1)) ? '0 : DATA_W'(1);

  // Next state, operand selection and start pulses
  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    base_d    = base_q;
    exp_d     = exp_q;
    mod_d     = mod_q;
    err_d     = err_q;
    mul_start = 1'b0;
    mul_req   = '{a: acc_q, b: base_q, m: mod_q};
    out_load  = 1'b0;
    decide    = 1'b0;
    nxt_exp   = exp_q;
    nxt_base  = base_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          exp_d = in_data_i.exponent;
          mod_d = in_data_i.modulus;
          if (in_data_i.modulus == '0) begin
            acc_d   = '0;
            err_d   = 1'b1;
            state_d = S_FINISH;
          end else begin
            // base mod m computed as (1 mod m) * base mod m
            acc_d     = acc_init;
            err_d     = 1'b0;
            mul_start = 1'b1;
            mul_req   = '{a: acc_init, b: in_data_i.base, m: in_data_i.modulus};
            state_d   = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mul_done) begin
          base_d   = mul_res;
          nxt_base = mul_res;
          decide   = 1'b1;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          acc_d     = mul_res;
          mul_start = 1'b1;
          mul_req   = '{a: base_q, b: base_q, m: mod_q};
          state_d   = S_SQR;
        end
      end
      S_SQR: begin
        if (mul_done) begin
          base_d   = mul_res;
          nxt_base = mul_res;
          nxt_exp  = {1'b0, exp_q[DATA_W-1:1]};
          exp_d    = nxt_exp;
          decide   = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Pick the work for the next exponent bit
    if (decide) begin
      if (nxt_exp == '0) begin
        state_d = S_FINISH;
      end else if (nxt_exp[0]) begin
        mul_start = 1'b1;
        mul_req   = '{a: acc_q, b: nxt_base, m: mod_q};
        state_d   = S_MUL;
      end else begin
        mul_start = 1'b1;
        mul_req   = '{a: nxt_base, b: nxt_base, m: mod_q};
        state_d   = S_SQR;
      end
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    err_q  <= err_d;
  end

  // Output register: holds a result until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= '{power_result: acc_q, zero_modulus_error: err_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/mexp_checker.sv
// Port-level checker for modular_exponentiation_64_top, attached by bind.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_checker import mexp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input mexp_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input mexp_out_t out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_modulus_error |-> out_data_o.power_result == '0)
    else $error("error result with nonzero value");

  // The block is busy right after taking an item
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // A new result appears only as the sequencer returns to idle
  a_new_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while still busy");

endmodule

bind modular_exponentiation_64_top mexp_checker u_mexp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
